### hw/rtl/lrm_pkg.sv
// lrm_pkg: shared types and constants of the stereo linear resampler and mixer
// used by every rtl file of the block, depends on nothing
`timescale 1ns / 1ps

package lrm_pkg;

  // input item codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_MIX  = 1'b1;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned FRAC_W   = 16;

  // phase step after reset, (32000 << 16) / 44100
  localparam logic [FRAC_W-1:0] STEP_RESET = 16'd47554;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // job queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = 2;
  localparam int unsigned QCW    = 3;

  // one mix job: phase weight, both stored frames and the frame to mix into
  typedef struct packed {
    logic        [FRAC_W-1:0]   phase;
    logic signed [SAMPLE_W-1:0] a_left;
    logic signed [SAMPLE_W-1:0] a_right;
    logic signed [SAMPLE_W-1:0] b_left;
    logic signed [SAMPLE_W-1:0] b_right;
    logic signed [SAMPLE_W-1:0] mix_left;
    logic signed [SAMPLE_W-1:0] mix_right;
  } lrm_job_t;

  // job queue status seen by the front
  typedef struct packed {
    logic [QCW-1:0] count;
  } lrm_qstat_t;

endpackage

### hw/rtl/linear_resample_mix_stereo_unit.sv
// linear_resample_mix_stereo_unit: top level of the stereo linear resampler and mixer
// depends on lrm_pkg, lrm_front, lrm_queue, lrm_back
//
//   port group   direction  handshake              payload
//   in           sink       in_valid_i/in_ready_o  func, block_start, src_*, mix_*
//   out          source     out_valid_o/out_ready_i out_left, out_right
//   cfg          sink       cfg_we_i (no wait)     cfg_data_i = phase step
//
// one item per cycle while in_ready_o is high; a mix beat passes the store read at the accepting edge,
// then the queue, the multiply stage and the sum and saturate into the output register; a load gives no beat
// the frame store has one write and two read ports, loads and mixes never collide
// in_ready_o drops only when the 4-entry job queue and the read stage hold 4 jobs
// reset clears positions and phase and restores the step; the store needs no clearing pass
`timescale 1ns / 1ps

module linear_resample_mix_stereo_unit #(
  parameter int unsigned STORE_DEPTH = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lrm_pkg::FRAC_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                func_i,
  input  logic                                block_start_i,
  input  logic signed [lrm_pkg::SAMPLE_W-1:0] src_left_i,
  input  logic signed [lrm_pkg::SAMPLE_W-1:0] src_right_i,
  input  logic signed [lrm_pkg::SAMPLE_W-1:0] mix_left_i,
  input  logic signed [lrm_pkg::SAMPLE_W-1:0] mix_right_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [lrm_pkg::SAMPLE_W-1:0] out_left_o,
  output logic signed [lrm_pkg::SAMPLE_W-1:0] out_right_o
);
  import lrm_pkg::*;

  lrm_qstat_t qstat;
  lrm_job_t   push_job, head_job;
  logic       push, pop, head_valid;

  lrm_front #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .block_start_i(block_start_i),
    .src_left_i   (src_left_i),
    .src_right_i  (src_right_i),
    .mix_left_i   (mix_left_i),
    .mix_right_i  (mix_right_i),
    .qstat_i      (qstat),
    .push_o       (push),
    .job_o        (push_job)
  );

  lrm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .valid_o(head_valid),
    .job_o  (head_job),
    .qstat_o(qstat)
  );

  lrm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(head_valid),
    .job_i      (head_job),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_left_o (out_left_o),
    .out_right_o(out_right_o)
  );

endmodule

### hw/rtl/lrm_front.sv
// lrm_front: accepts items, keeps positions and phase, owns the frame store
// depends on lrm_pkg
`timescale 1ns / 1ps

module lrm_front #(
  parameter int unsigned STORE_DEPTH = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lrm_pkg::FRAC_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            func_i,
  input  logic                            block_start_i,
  input  logic signed [lrm_pkg::SAMPLE_W-1:0] src_left_i,
  input  logic signed [lrm_pkg::SAMPLE_W-1:0] src_right_i,
  input  logic signed [lrm_pkg::SAMPLE_W-1:0] mix_left_i,
  input  logic signed [lrm_pkg::SAMPLE_W-1:0] mix_right_i,
  input  lrm_pkg::lrm_qstat_t             qstat_i,
  output logic                            push_o,
  output lrm_pkg::lrm_job_t               job_o
);
  import lrm_pkg::*;

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam logic [AW-1:0] LAST_POS = AW'(STORE_DEPTH - 1);

  function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
    next_pos = (p == LAST_POS) ? '0 : p + AW'(1);
  endfunction

  logic [2*SAMPLE_W-1:0] frame_mem [STORE_DEPTH];

  logic [FRAC_W-1:0] step_q;
  logic [AW-1:0]     write_pos_q, write_pos_d;
  logic [AW-1:0]     read_pos_q, read_pos_d;
  logic [FRAC_W-1:0] phase_q, phase_d;
  logic              s1_valid_q;

  logic [2*SAMPLE_W-1:0]      rd0_q, rd1_q;
  logic [FRAC_W-1:0]          s1_phase_q;
  logic signed [SAMPLE_W-1:0] s1_mix_left_q, s1_mix_right_q;

  logic          accept, load, mix;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_next;
  logic [FRAC_W:0] phase_sum;

  // credit check: queued jobs plus the one in the read stage
  assign in_ready_o = (qstat_i.count + QCW'(s1_valid_q)) < QCW'(QDEPTH);
  assign accept     = in_valid_i && in_ready_o;
  assign load       = accept && (func_i == FUNC_LOAD);
  assign mix        = accept && (func_i == FUNC_MIX);
  assign wr_addr    = block_start_i ? '0 : write_pos_q;
  assign rd_next    = next_pos(read_pos_q);
  assign phase_sum  = {1'b0, phase_q} + {1'b0, step_q};

  always_comb begin
    write_pos_d = write_pos_q;
    read_pos_d  = read_pos_q;
    phase_d     = phase_q;
    if (load) begin
      write_pos_d = next_pos(wr_addr);
      if (block_start_i) begin
        read_pos_d = '0;
        phase_d    = '0;
      end
    end else if (mix) begin
      phase_d = phase_sum[FRAC_W-1:0];
      // carry out of the fraction moves on one source frame
      if (phase_sum[FRAC_W]) begin
        read_pos_d = rd_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_RESET;
      write_pos_q <= '0;
      read_pos_q  <= '0;
      phase_q     <= '0;
      s1_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        step_q <= cfg_data_i;
      end
      write_pos_q <= write_pos_d;
      read_pos_q  <= read_pos_d;
      phase_q     <= phase_d;
      s1_valid_q  <= mix;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      frame_mem[wr_addr] <= {src_right_i, src_left_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mix) begin
      rd0_q          <= frame_mem[read_pos_q];
      rd1_q          <= frame_mem[rd_next];
      s1_phase_q     <= phase_q;
      s1_mix_left_q  <= mix_left_i;
      s1_mix_right_q <= mix_right_i;
    end
  end

  assign push_o = s1_valid_q;

  always_comb begin
    job_o.phase     = s1_phase_q;
    job_o.a_left    = rd0_q[SAMPLE_W-1:0];
    job_o.a_right   = rd0_q[2*SAMPLE_W-1:SAMPLE_W];
    job_o.b_left    = rd1_q[SAMPLE_W-1:0];
    job_o.b_right   = rd1_q[2*SAMPLE_W-1:SAMPLE_W];
    job_o.mix_left  = s1_mix_left_q;
    job_o.mix_right = s1_mix_right_q;
  end

endmodule

### hw/rtl/lrm_queue.sv
// lrm_queue: short job queue between front and back
// depends on lrm_pkg
`timescale 1ns / 1ps

module lrm_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lrm_pkg::lrm_job_t   job_i,
  input  logic                pop_i,
  output logic                valid_o,
  output lrm_pkg::lrm_job_t   job_o,
  output lrm_pkg::lrm_qstat_t qstat_o
);
  import lrm_pkg::*;

  lrm_job_t       slot_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0] count_q, count_d;
  logic           do_pop;

  // the front only pushes when it holds a credit, so no full check here
  assign valid_o = (count_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign job_o   = slot_q[rd_ptr_q];
  assign qstat_o.count = count_q;

  always_comb begin
    count_d = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + QCW'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QAW'(1);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

### hw/rtl/lrm_back.sv
// lrm_back: interpolation multiply stage, then sum, mix and saturate into the output register
// depends on lrm_pkg
`timescale 1ns / 1ps

module lrm_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               job_valid_i,
  input  lrm_pkg::lrm_job_t                  job_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [lrm_pkg::SAMPLE_W-1:0] out_left_o,
  output logic signed [lrm_pkg::SAMPLE_W-1:0] out_right_o
);
  import lrm_pkg::*;

  localparam int unsigned PA_W = 34;
  localparam int unsigned PB_W = 33;
  localparam int unsigned ACC_W = 35;

  logic                       b1_valid_q;
  logic signed [PA_W-1:0]     pa_l_q, pa_r_q, pa_l_d, pa_r_d;
  logic signed [PB_W-1:0]     pb_l_q, pb_r_q, pb_l_d, pb_r_d;
  logic signed [SAMPLE_W-1:0] b1_mix_l_q, b1_mix_r_q;
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_l_q, out_r_q, out_l_d, out_r_d;

  logic              out_adv, b1_adv;
  logic [FRAC_W:0]   w_early;
  logic signed [ACC_W-1:0] acc_l, acc_r;

  function automatic logic signed [SAMPLE_W-1:0] mix_sat(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b
  );
    logic signed [SAMPLE_W:0] s;
    s = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
    if (s[SAMPLE_W] != s[SAMPLE_W-1]) begin
      mix_sat = s[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
    end else begin
      mix_sat = s[SAMPLE_W-1:0];
    end
  endfunction

  assign out_adv = !out_valid_q || out_ready_i;
  assign b1_adv  = !b1_valid_q || out_adv;
  assign pop_o   = job_valid_i && b1_adv;

  // weight of the earlier frame, 0x10000 - phase
  assign w_early = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, job_i.phase};

  always_comb begin
    pa_l_d = PA_W'(job_i.a_left)  * PA_W'($signed({1'b0, w_early}));
    pa_r_d = PA_W'(job_i.a_right) * PA_W'($signed({1'b0, w_early}));
    pb_l_d = PB_W'(job_i.b_left)  * PB_W'($signed({1'b0, job_i.phase}));
    pb_r_d = PB_W'(job_i.b_right) * PB_W'($signed({1'b0, job_i.phase}));
  end

  // sum stays within 32 signed bits, floor shift keeps bits 31..16
  assign acc_l = ACC_W'(pa_l_q) + ACC_W'(pb_l_q);
  assign acc_r = ACC_W'(pa_r_q) + ACC_W'(pb_r_q);

  always_comb begin
    out_l_d = mix_sat(b1_mix_l_q, acc_l[FRAC_W+SAMPLE_W-1:FRAC_W]);
    out_r_d = mix_sat(b1_mix_r_q, acc_r[FRAC_W+SAMPLE_W-1:FRAC_W]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (b1_adv) begin
        b1_valid_q <= job_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= b1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pa_l_q     <= pa_l_d;
      pa_r_q     <= pa_r_d;
      pb_l_q     <= pb_l_d;
      pb_r_q     <= pb_r_d;
      b1_mix_l_q <= job_i.mix_left;
      b1_mix_r_q <= job_i.mix_right;
    end
    if (out_adv && b1_valid_q) begin
      out_l_q <= out_l_d;
      out_r_q <= out_r_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_left_o  = out_l_q;
  assign out_right_o = out_r_q;

endmodule

### hw/rtl/lrm_checker.sv
// lrm_checker: port-level assertions for the stereo resampler and mixer, bound to the top level
// depends on lrm_pkg and linear_resample_mix_stereo_unit
`timescale 1ns / 1ps

module lrm_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                func_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [lrm_pkg::SAMPLE_W-1:0] out_left_o,
  input logic signed [lrm_pkg::SAMPLE_W-1:0] out_right_o
);
  import lrm_pkg::*;

  // read stage plus queue share the credit, then multiply and output stages
  localparam int unsigned MAX_PENDING = QDEPTH + 2;

  logic [3:0] pending_q;
  logic       mix_beat, out_beat;

  assign mix_beat = in_valid_i && in_ready_o && (func_i == FUNC_MIX);
  assign out_beat = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 4'(mix_beat) - 4'(out_beat);
    end
  end

  // a beat only ever answers a mix taken earlier
  a_out_has_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pending_q != '0))
    else $error("output beat with no mix outstanding");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 4'(MAX_PENDING))
    else $error("more mixes in flight than the pipeline holds");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q == '0) |-> in_ready_o)
    else $error("input stalled with nothing in flight");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("output beat withdrawn before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> ($stable(out_left_o) && $stable(out_right_o)))
    else $error("output payload changed while stalled");

endmodule

bind linear_resample_mix_stereo_unit lrm_checker u_lrm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .func_i     (func_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_left_o (out_left_o),
  .out_right_o(out_right_o)
);
